// ===== rtl/markup_and_uuencode_discard_filter_defines.svh =====
// ----------------------------------------------------------------------------
// markup and uuencode discard filter: assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MARKUP_AND_UUENCODE_DISCARD_FILTER_DEFINES_SVH
`define MARKUP_AND_UUENCODE_DISCARD_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

`define MUDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mudf assertion failed");

`define MUDF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mudf forbidden condition");

`else

`define MUDF_ASSERT(lbl, prop)

`define MUDF_NEVER(lbl, expr)

`endif

`endif

// ===== rtl/mudf_pkg.sv =====
// ----------------------------------------------------------------------------
// mudf_pkg
// shared types and constants of the markup and uuencode discard filter
// ----------------------------------------------------------------------------
`default_nettype none

package mudf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STATE_W = 4;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [STATE_W-1:0] state_t;

  // uuencode automaton states
  localparam state_t UU_IDLE   = 4'd0;
  localparam state_t UU_B      = 4'd1;
  localparam state_t UU_E      = 4'd2;
  localparam state_t UU_G      = 4'd3;
  localparam state_t UU_I      = 4'd4;
  localparam state_t UU_N      = 4'd5;
  localparam state_t UU_SP1    = 4'd6;
  localparam state_t UU_D1     = 4'd7;
  localparam state_t UU_D2     = 4'd8;
  localparam state_t UU_D3     = 4'd9;
  localparam state_t UU_EOL    = 4'd10;
  localparam state_t UU_LSTART = 4'd11;
  localparam state_t UU_LINE   = 4'd12;

  // markup automaton states
  localparam state_t TG_TEXT   = 4'd0;
  localparam state_t TG_TAG    = 4'd1;
  localparam state_t TG_SQUOTE = 4'd4;
  localparam state_t TG_DQUOTE = 4'd5;

  localparam state_t UU_SKIP_FROM = UU_LSTART;

  // characters
  localparam byte_t CH_NL     = 8'h0a;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_7      = 8'h37;
  localparam byte_t CH_LT     = 8'h3c;
  localparam byte_t CH_GT     = 8'h3e;
  localparam byte_t CH_M      = 8'h4d;
  localparam byte_t CH_BQUOTE = 8'h60;
  localparam byte_t CH_B      = 8'h62;
  localparam byte_t CH_E      = 8'h65;
  localparam byte_t CH_G      = 8'h67;
  localparam byte_t CH_I      = 8'h69;
  localparam byte_t CH_N      = 8'h6e;

  typedef struct packed {
    logic   keep;
    state_t next_state;
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/mudf_step.sv =====
// ----------------------------------------------------------------------------
// mudf_step
// next-state and keep decision of both automata for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module mudf_step
  import mudf_pkg::*;
(
  input  wire logic      markup_mode,
  input  wire state_t    cur_state,
  input  wire logic      new_part,
  input  wire byte_t     data_byte,
  output step_res_t      res
);

  state_t raw_s;
  state_t s;
  state_t uu_nxt;
  state_t tg_nxt;
  logic   is_octal;

  assign raw_s    = new_part ? UU_IDLE : cur_state;
  assign is_octal = (data_byte >= CH_0) && (data_byte <= CH_7);

  // unused codes of the selected automaton act as state zero
  always_comb begin
    s = raw_s;
    if (markup_mode) begin
      if (!(raw_s inside {TG_TEXT, TG_TAG, TG_SQUOTE, TG_DQUOTE})) begin
        s = TG_TEXT;
      end
    end else begin
      if (raw_s > UU_LINE) begin
        s = UU_IDLE;
      end
    end
  end

  always_comb begin
    case (s)
      UU_IDLE:   uu_nxt = (data_byte == CH_B) ? UU_B : UU_IDLE;
      UU_B:      uu_nxt = (data_byte == CH_E) ? UU_E : UU_IDLE;
      UU_E:      uu_nxt = (data_byte == CH_G) ? UU_G : UU_IDLE;
      UU_G:      uu_nxt = (data_byte == CH_I) ? UU_I : UU_IDLE;
      UU_I:      uu_nxt = (data_byte == CH_N) ? UU_N : UU_IDLE;
      UU_N:      uu_nxt = (data_byte == CH_SPACE) ? UU_SP1 : UU_IDLE;
      UU_SP1:    uu_nxt = is_octal ? UU_D1 : UU_IDLE;
      UU_D1:     uu_nxt = is_octal ? UU_D2 : UU_IDLE;
      UU_D2:     uu_nxt = is_octal ? UU_D3 : UU_IDLE;
      UU_D3:     uu_nxt = (data_byte == CH_SPACE) ? UU_EOL : UU_IDLE;
      UU_EOL:    uu_nxt = (data_byte == CH_NL) ? UU_LSTART : UU_EOL;
      UU_LSTART: uu_nxt = (data_byte == CH_M) ? UU_LINE : UU_IDLE;
      default: begin
        uu_nxt = (data_byte inside {[CH_SPACE:CH_BQUOTE]}) ? UU_LINE : UU_LSTART;
      end
    endcase
  end

  always_comb begin
    case (s)
      TG_TEXT: tg_nxt = (data_byte == CH_LT) ? TG_TAG : TG_TEXT;
      TG_TAG: begin
        if (data_byte == CH_SQUOTE) begin
          tg_nxt = TG_SQUOTE;
        end else if (data_byte == CH_DQUOTE) begin
          tg_nxt = TG_DQUOTE;
        end else if (data_byte == CH_GT) begin
          tg_nxt = TG_TEXT;
        end else begin
          tg_nxt = TG_TAG;
        end
      end
      TG_SQUOTE: tg_nxt = (data_byte == CH_SQUOTE) ? TG_TAG : TG_SQUOTE;
      default:   tg_nxt = (data_byte == CH_DQUOTE) ? TG_TAG : TG_DQUOTE;
    endcase
  end

  always_comb begin
    if (markup_mode) begin
      res.keep       = (s == TG_TEXT);
      res.next_state = tg_nxt;
    end else begin
      res.keep       = (s < UU_SKIP_FROM);
      res.next_state = uu_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/markup_and_uuencode_discard_filter.sv =====
// ----------------------------------------------------------------------------
// markup_and_uuencode_discard_filter
// byte stream filter that drops uuencoded bodies or markup tags
// ----------------------------------------------------------------------------
// usage
//   in_*   : one text byte per transfer, in_tdata = data_byte, in_tuser = new_part
//            (restarts the automaton before this byte)
//   out_*  : one transfer per kept byte, dropped bytes produce nothing
//   cfg_*  : markup_mode, 0 uuencode automaton, 1 tag automaton; write only
//            while the stream is idle, the automaton state is not cleared
// latency: a byte taken at edge n is offered on out_* after edge n+1
// throughput: one byte per cycle; the state update of the step function
//   sits between the input register and the output register
// reset: rst_n low clears both registers' valid flags, the automaton state
//   and markup_mode
// stall: a kept byte waits in the output register; the input register then
//   holds its byte and in_tready falls once both are full; dropped bytes
//   still drain while the output waits
// ----------------------------------------------------------------------------
`default_nettype none

`include "markup_and_uuencode_discard_filter_defines.svh"

module markup_and_uuencode_discard_filter
  import mudf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,   // markup_mode

  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,      // [7:0] data_byte
  input  wire logic       in_tuser,      // [0] new_part

  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata      // [7:0] kept_byte
);

  logic      mode_r;
  state_t    scan_state_r;
  state_t    scan_state_nxt;

  logic      s1_valid_r;
  byte_t     s1_byte_r;
  logic      s1_new_part_r;

  logic      out_valid_r;
  logic      out_valid_nxt;
  byte_t     out_byte_r;

  step_res_t res;
  logic      out_free;
  logic      s1_adv;
  logic      in_xfer;

  mudf_step u_step (
    .markup_mode (mode_r),
    .cur_state   (scan_state_r),
    .new_part    (s1_new_part_r),
    .data_byte   (s1_byte_r),
    .res         (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!res.keep || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  assign scan_state_nxt = s1_adv ? res.next_state : scan_state_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv && res.keep) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      scan_state_r <= UU_IDLE;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      scan_state_r <= scan_state_nxt;
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r     <= in_tdata;
      s1_new_part_r <= in_tuser;
    end
    if (s1_adv && res.keep) begin
      out_byte_r <= s1_byte_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;

  `MUDF_NEVER(a_state_in_range, scan_state_r > UU_LINE)
  `MUDF_ASSERT(a_keep_loads_out, (s1_adv && res.keep) |=> out_valid_r)
  `MUDF_ASSERT(a_blocked_holds, (s1_valid_r && !s1_adv) |=>
    (s1_valid_r && $stable(scan_state_r) && $stable(s1_byte_r)))

endmodule

`default_nettype wire
